// ===== src/hkrt_pkg.sv =====
// ----------------------------------------------------------------------------
// hkrt_pkg
// Shared types, operation codes and the ascii-to-usage rom for the keyboard
// report tracker.
// ----------------------------------------------------------------------------
package hkrt_pkg;

    localparam int NUM_SLOTS = 6;

    // operation codes
    localparam logic [1:0] OP_PRESS       = 2'd0;
    localparam logic [1:0] OP_RELEASE     = 2'd1;
    localparam logic [1:0] OP_RELEASE_ALL = 2'd2;
    localparam logic [1:0] OP_SEND        = 2'd3;

    // key code ranges and rom entry bits
    localparam logic [7:0] RAW_BASE       = 8'd136;
    localparam logic [7:0] MOD_BASE       = 8'd128;
    localparam logic [7:0] ROM_SHIFT      = 8'h80;
    localparam logic [7:0] LEFT_SHIFT_BIT = 8'h02;
    localparam logic [7:0] USAGE_MASK     = 8'h7F;
    localparam logic [7:0] USAGE_NONE     = 8'h00;

    // decoded key
    typedef struct packed {
        logic       valid;     // rom did not reject the code
        logic       mod_hit;   // a modifier bit is touched
        logic [7:0] mod_mask;  // which modifier bit
        logic [7:0] usage;     // usage for the slots, 0 for none
    } hkrt_key_t;

    // slot update status
    typedef struct packed {
        logic held;       // usage already in a slot
        logic has_space;  // at least one slot is empty
        logic changed;    // a slot was written or cleared
    } hkrt_slot_status_t;

    // ascii to usage rom, bit 7 asks for left shift
    localparam logic [7:0] ASCII_ROM [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
        8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
        8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
        8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
        8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
        8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
        8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
        8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
        8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
        8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
    };

endpackage

// ===== src/hid_keyboard_report_tracker_core.sv =====
// ----------------------------------------------------------------------------
// hid_keyboard_report_tracker_core
// Six-key rollover keyboard report: modifier byte, six key slots and a
// dirty flag, updated by press, release, release-all and send commands.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------------
//   command   | start / busy         | operation, key_code, link_connected
//   result    | done (strobe)        | accepted, notify, modifier_bits,
//             |                      | slot_zero .. slot_five
//
// a command is registered on the transfer edge and its result strobes on
// done from the result register behind the command register, one command per cycle sustained.
// the decode rom and six slot compares are combinational between the command
// register and the report state; busy stays low.
// reset clears the report and marks it pending; the receiver cannot stall,
// report fields reflect the state after the command and hold until the next.
// ----------------------------------------------------------------------------
module hid_keyboard_report_tracker_core
    import hkrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [7:0] key_code,
    input  logic       link_connected,
    output logic       done,
    output logic       accepted,
    output logic       notify,
    output logic [7:0] modifier_bits,
    output logic [7:0] slot_zero,
    output logic [7:0] slot_one,
    output logic [7:0] slot_two,
    output logic [7:0] slot_three,
    output logic [7:0] slot_four,
    output logic [7:0] slot_five
);

    logic              item_valid_reg;
    logic [1:0]        op_reg;
    logic [7:0]        code_reg;
    logic              link_reg;

    logic [7:0]        modifier_reg;
    logic [7:0]        modifier_next;
    logic [7:0]        slot_reg  [NUM_SLOTS];
    logic [7:0]        slot_next [NUM_SLOTS];
    logic [7:0]        slot_upd  [NUM_SLOTS];
    logic              dirty_reg;
    logic              dirty_next;

    logic              done_reg;
    logic              accepted_reg;
    logic              accepted_next;
    logic              notify_reg;
    logic              notify_next;

    hkrt_key_t         key;
    hkrt_slot_status_t slot_status;

    assign busy = 1'b0;

    // command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg   <= operation;
            code_reg <= key_code;
            link_reg <= link_connected;
        end
    end

    // key decode
    hkrt_decode u_decode
    (
        .key_code (code_reg),
        .key      (key)
    );

    // slot compares
    hkrt_slots u_slots
    (
        .slots      (slot_reg),
        .usage      (key.usage),
        .do_press   ((op_reg == OP_PRESS) && key.valid),
        .do_release ((op_reg == OP_RELEASE) && key.valid),
        .slots_next (slot_upd),
        .status     (slot_status)
    );

    // report update for the registered command
    always_comb
    begin
        modifier_next = modifier_reg;
        dirty_next    = dirty_reg;
        accepted_next = 1'b1;
        notify_next   = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        case (op_reg)
            OP_PRESS:
            begin
                if (!key.valid)
                begin
                    accepted_next = 1'b0;
                end
                else
                begin
                    if (key.mod_hit)
                    begin
                        modifier_next = modifier_reg | key.mod_mask;
                        dirty_next    = 1'b1;
                    end
                    if (slot_status.changed)
                    begin
                        dirty_next = 1'b1;
                    end
                    slot_next     = slot_upd;
                    accepted_next = slot_status.held || slot_status.has_space;
                end
            end
            OP_RELEASE:
            begin
                if (!key.valid)
                begin
                    accepted_next = 1'b0;
                end
                else
                begin
                    if (key.mod_hit)
                    begin
                        modifier_next = modifier_reg & ~key.mod_mask;
                        dirty_next    = 1'b1;
                    end
                    if (slot_status.changed)
                    begin
                        dirty_next = 1'b1;
                    end
                    slot_next = slot_upd;
                end
            end
            OP_RELEASE_ALL:
            begin
                modifier_next = '0;
                dirty_next    = 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    slot_next[i] = USAGE_NONE;
                end
            end
            OP_SEND:
            begin
                if (link_reg && dirty_reg)
                begin
                    notify_next = 1'b1;
                    dirty_next  = 1'b0;
                end
            end
            default:
            begin
                accepted_next = 1'b1;
            end
        endcase
    end

    // report state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modifier_reg <= '0;
            dirty_reg    <= 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_reg[i] <= USAGE_NONE;
            end
        end
        else if (item_valid_reg)
        begin
            modifier_reg <= modifier_next;
            dirty_reg    <= dirty_next;
            slot_reg     <= slot_next;
        end
    end

    // result strobe and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid_reg)
        begin
            accepted_reg <= accepted_next;
            notify_reg   <= notify_next;
        end
    end

    // result ports
    assign done          = done_reg;
    assign accepted      = accepted_reg;
    assign notify        = notify_reg;
    assign modifier_bits = modifier_reg;
    assign slot_zero     = slot_reg[0];
    assign slot_one      = slot_reg[1];
    assign slot_two      = slot_reg[2];
    assign slot_three    = slot_reg[3];
    assign slot_four     = slot_reg[4];
    assign slot_five     = slot_reg[5];

`ifndef NO_ASSERTIONS
    // every registered command gives exactly one result in the following cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |=> done_reg)
        else $error("registered command gave no result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |=> !done_reg)
        else $error("result without a command");

    // a notify leaves the report clean and is always accepted
    a_notify_clears_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && notify_reg) |-> (!dirty_reg && accepted_reg))
        else $error("notify left the report dirty");

    // only press and release can be refused
    a_reject_op: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !accepted_next) |->
            ((op_reg == OP_PRESS) || (op_reg == OP_RELEASE)))
        else $error("release-all or send refused");
`endif

endmodule

// ===== src/hkrt_decode.sv =====
// ----------------------------------------------------------------------------
// hkrt_decode
// Turns a key code into a usage and a modifier bit: raw usages, modifier
// codes and ascii through the rom.
// ----------------------------------------------------------------------------
module hkrt_decode
    import hkrt_pkg::*;
(
    input  logic [7:0] key_code,
    output hkrt_key_t  key
);

    logic [7:0] rom_entry;

    // rom lookup on the low seven bits
    assign rom_entry = ASCII_ROM[key_code[6:0]];

    // classify the code
    always_comb
    begin
        key = '0;
        if (key_code >= RAW_BASE)
        begin
            key.valid = 1'b1;
            key.usage = key_code - RAW_BASE;
        end
        else if (key_code >= MOD_BASE)
        begin
            key.valid    = 1'b1;
            key.mod_hit  = 1'b1;
            key.mod_mask = 8'd1 << key_code[2:0];
            key.usage    = USAGE_NONE;
        end
        else if (rom_entry != USAGE_NONE)
        begin
            key.valid = 1'b1;
            key.usage = rom_entry & USAGE_MASK;
            if ((rom_entry & ROM_SHIFT) != USAGE_NONE)
            begin
                key.mod_hit  = 1'b1;
                key.mod_mask = LEFT_SHIFT_BIT;
            end
        end
    end

endmodule

// ===== src/hkrt_slots.sv =====
// ----------------------------------------------------------------------------
// hkrt_slots
// Six parallel slot compares: held check, first empty slot on press and
// clearing of every matching slot on release.
// ----------------------------------------------------------------------------
module hkrt_slots
    import hkrt_pkg::*;
(
    input  logic [7:0]        slots      [NUM_SLOTS],
    input  logic [7:0]        usage,
    input  logic              do_press,
    input  logic              do_release,
    output logic [7:0]        slots_next [NUM_SLOTS],
    output hkrt_slot_status_t status
);

    logic [NUM_SLOTS-1:0] match;
    logic [NUM_SLOTS-1:0] empty;
    logic [NUM_SLOTS-1:0] first_empty;

    // per-slot compares
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            match[i] = (slots[i] == usage);
            empty[i] = (slots[i] == USAGE_NONE);
        end
    end

    // one-hot first empty slot
    assign first_empty = empty & (~empty + 1'b1);

    // slot update
    always_comb
    begin
        status.held      = |match;
        status.has_space = |empty;
        status.changed   = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slots_next[i] = slots[i];
        end
        if (do_press && !status.held)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (first_empty[i])
                begin
                    slots_next[i] = usage;
                end
            end
            status.changed = status.has_space;
        end
        else if (do_release && (usage != USAGE_NONE))
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (match[i])
                begin
                    slots_next[i] = USAGE_NONE;
                end
            end
            status.changed = |match;
        end
    end

endmodule
